[rtl/pid_controller_variable_dt_macros.svh]
// assertion macros for the pid controller block
`ifndef PID_CONTROLLER_VARIABLE_DT_MACROS_SVH
`define PID_CONTROLLER_VARIABLE_DT_MACROS_SVH

// same-cycle implication, checked outside reset
`define PIDVDT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pid controller check failed");

// next-cycle implication, checked outside reset
`define PIDVDT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pid controller check failed");

`endif

[rtl/pidvdt_pkg.sv]
// shared types, constants, arithmetic helpers and microcode table
package pidvdt_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int STEP_W = 4;
  localparam int DIV_CNT_W = 6;

  // config register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT   = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_LIMIT_LOW  = 3'd4,
    REG_LIMIT_HIGH = 3'd5
  } reg_idx_t;

  localparam logic [31:0] MS_PER_S = 32'd1000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [64:0] WIDE_MAX = 65'sd2147483647;
  localparam logic signed [64:0] WIDE_MIN = -65'sd2147483648;

  // divider: two quotient bits per cycle by dt, 16-bit digits by 1000
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam logic [DIV_CNT_W-1:0] DIV_MS_CYCLES = 6'd8;
  localparam logic [DIV_CNT_W-1:0] DIV_SHORT_CYCLES = 6'd22;
  localparam int DIV_SHORT_SHIFT = 64 - DIV_BITS_PER_CYCLE * 22;
  // ceil(2^36 / 1000), exact for digit chunks below 2^26
  localparam logic [26:0] DIV_MS_RECIP = 27'd68719477;
  localparam int DIV_MS_SHIFT = 36;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_ERR_KP, MUL_ERR_KI, MUL_DM_KD, MUL_QI_DT, MUL_QD_MS
  } mul_sel_t;

  typedef enum logic [1:0] {Q_NONE, Q_P, Q_QI, Q_QD} q_dst_t;
  typedef enum logic [1:0] {DIV_NONE, DIV_BY_MS, DIV_BY_DT} div_op_t;
  typedef enum logic [1:0] {RES_NONE, RES_INTEGRAL, RES_DTERM} res_dst_t;
  typedef enum logic [1:0] {OUT_NONE, OUT_FULL, OUT_P} out_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT, JMP_WAIT_IN, JMP_SKIP, JMP_WAIT_DIV, JMP_WAIT_OUT, JMP_GOTO
  } jmp_t;

  // one microcode word
  typedef struct packed {
    logic     take_in;
    logic     prep;
    mul_sel_t mul_sel;
    q_dst_t   q_dst;
    div_op_t  div_op;
    res_dst_t res_dst;
    out_op_t  out_op;
    jmp_t     jmp;
    step_t    target;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic in_take;
    logic skip;
    logic div_busy;
    logic out_busy;
  } cond_t;

  typedef struct packed {
    logic               start;
    logic               by_dt;
    logic signed [63:0] dividend;
    logic [31:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic signed [63:0] quot;
  } div_res_t;

  // program steps
  localparam step_t ST_IDLE    = 4'd0;
  localparam step_t ST_PREP    = 4'd1;
  localparam step_t ST_MUL_P   = 4'd2;
  localparam step_t ST_MUL_I   = 4'd3;
  localparam step_t ST_MUL_D   = 4'd4;
  localparam step_t ST_MUL_DT  = 4'd5;
  localparam step_t ST_DIV_MS  = 4'd6;
  localparam step_t ST_WAIT_MS = 4'd7;
  localparam step_t ST_DIV_DT  = 4'd8;
  localparam step_t ST_WAIT_DT = 4'd9;
  localparam step_t ST_OUT     = 4'd10;
  localparam step_t ST_OUT_P   = 4'd11;

  localparam ctrl_t CTRL_NOP = '{
    take_in: 1'b0, prep: 1'b0, mul_sel: MUL_NONE, q_dst: Q_NONE,
    div_op: DIV_NONE, res_dst: RES_NONE, out_op: OUT_NONE,
    jmp: JMP_NEXT, target: ST_IDLE
  };

  // control store
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c = CTRL_NOP;
    unique case (s)
      ST_IDLE: begin
        c.take_in = 1'b1;
        c.jmp = JMP_WAIT_IN;
      end
      ST_PREP: begin
        c.prep = 1'b1;
      end
      ST_MUL_P: begin
        c.mul_sel = MUL_ERR_KP;
      end
      ST_MUL_I: begin
        c.q_dst = Q_P;
        c.mul_sel = MUL_ERR_KI;
        c.jmp = JMP_SKIP;
        c.target = ST_OUT_P;
      end
      ST_MUL_D: begin
        c.q_dst = Q_QI;
        c.mul_sel = MUL_DM_KD;
      end
      ST_MUL_DT: begin
        c.q_dst = Q_QD;
        c.mul_sel = MUL_QI_DT;
      end
      ST_DIV_MS: begin
        c.mul_sel = MUL_QD_MS;
        c.div_op = DIV_BY_MS;
      end
      ST_WAIT_MS: begin
        c.res_dst = RES_INTEGRAL;
        c.jmp = JMP_WAIT_DIV;
      end
      ST_DIV_DT: begin
        c.div_op = DIV_BY_DT;
      end
      ST_WAIT_DT: begin
        c.res_dst = RES_DTERM;
        c.jmp = JMP_WAIT_DIV;
      end
      ST_OUT: begin
        c.out_op = OUT_FULL;
        c.jmp = JMP_WAIT_OUT;
        c.target = ST_IDLE;
      end
      ST_OUT_P: begin
        c.out_op = OUT_P;
        c.jmp = JMP_WAIT_OUT;
        c.target = ST_IDLE;
      end
      default: begin
        c.jmp = JMP_GOTO;
        c.target = ST_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [64:0] sx65(input logic signed [31:0] v);
    return $signed({{33{v[31]}}, v});
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
    logic signed [31:0] r;
    if (x > WIDE_MAX) begin
      r = S32_MAX;
    end else if (x < WIDE_MIN) begin
      r = S32_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // q16.16 product: floor by 2^16, then saturate
  function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
    logic signed [47:0] s;
    s = p[63:16];
    return sat32($signed({{17{s[47]}}, s}));
  endfunction

  // upper limit first, lower limit second
  function automatic logic signed [31:0] clamp_lim(input logic signed [64:0] x,
                                                   input logic signed [31:0] lo,
                                                   input logic signed [31:0] hi);
    logic signed [64:0] r;
    r = x;
    if (r > sx65(hi)) begin
      r = sx65(hi);
    end
    if (r < sx65(lo)) begin
      r = sx65(lo);
    end
    return r[31:0];
  endfunction

endpackage

[rtl/pidvdt_div.sv]
// divider, truncating: two bits per cycle by dt, reciprocal digits by 1000
module pidvdt_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pidvdt_pkg::div_req_t req,
  output pidvdt_pkg::div_res_t res
);
  import pidvdt_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r;
  logic [63:0]          quo_r, quo_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [31:0]          divisor_r;
  logic                 neg_r;
  logic                 by_ms_r;
  logic [15:0]          qdig_r;
  logic [63:0]          mag;
  logic [32:0]          trial;
  logic [25:0]          chunk;
  logic [51:0]          recip_prod;
  logic [15:0]          qdig;
  logic [25:0]          rem_ms;

  // dividend magnitude
  assign mag = req.dividend[63] ? (~req.dividend + 64'd1) : req.dividend;

  // restoring steps for one cycle
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial = '0;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      trial = {rem_nxt, quo_nxt[63]};
      quo_nxt = {quo_nxt[62:0], 1'b0};
      if (trial >= {1'b0, divisor_r}) begin
        trial = trial - {1'b0, divisor_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[31:0];
    end
  end

  // by 1000: remainder and next 16-bit digit, quotient digit by reciprocal
  assign chunk      = {rem_r[9:0], quo_r[63:48]};
  assign recip_prod = {26'd0, chunk} * {25'd0, DIV_MS_RECIP};
  assign qdig       = 16'(recip_prod >> DIV_MS_SHIFT);
  assign rem_ms     = chunk - ({10'd0, qdig_r} * MS_PER_S[25:0]);

  // cycle counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= req.by_dt ? DIV_SHORT_CYCLES : DIV_MS_CYCLES;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  // quotient and remainder; by 1000 alternates digit estimate and remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r     <= req.by_dt ? (mag << DIV_SHORT_SHIFT) : mag;
      rem_r     <= '0;
      divisor_r <= req.divisor;
      neg_r     <= req.dividend[63];
      by_ms_r   <= !req.by_dt;
    end else if (cnt_r != '0) begin
      if (!by_ms_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
      end else if (!cnt_r[0]) begin
        qdig_r <= qdig;
      end else begin
        quo_r <= {quo_r[47:0], qdig_r};
        rem_r <= 32'(rem_ms);
      end
    end
  end

  assign res.busy = (cnt_r != '0);
  assign res.quot = neg_r ? $signed(~quo_r + 64'd1) : $signed(quo_r);

endmodule

[rtl/pidvdt_seq.sv]
// step counter and control store with conditional jumps
module pidvdt_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  pidvdt_pkg::cond_t cond,
  output pidvdt_pkg::ctrl_t ctrl,
  output pidvdt_pkg::step_t pc
);
  import pidvdt_pkg::*;

  step_t pc_r, pc_nxt;
  step_t pc_inc;

  assign ctrl = ucode(pc_r);
  assign pc = pc_r;
  assign pc_inc = pc_r + 4'd1;

  // next step
  always_comb begin
    unique case (ctrl.jmp)
      JMP_NEXT:     pc_nxt = pc_inc;
      JMP_WAIT_IN:  pc_nxt = cond.in_take ? pc_inc : pc_r;
      JMP_SKIP:     pc_nxt = cond.skip ? ctrl.target : pc_inc;
      JMP_WAIT_DIV: pc_nxt = cond.div_busy ? pc_r : pc_inc;
      JMP_WAIT_OUT: pc_nxt = cond.out_busy ? pc_r : ctrl.target;
      JMP_GOTO:     pc_nxt = ctrl.target;
      default:      pc_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ST_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[rtl/pidvdt_dpath.sv]
// datapath: config registers, state, shared multiplier, output register
module pidvdt_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pidvdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_measured_value,
  input  logic [31:0]                 in_time_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_drive_value,
  input  pidvdt_pkg::ctrl_t           ctrl,
  output pidvdt_pkg::cond_t           cond,
  output pidvdt_pkg::div_req_t        div_req,
  input  pidvdt_pkg::div_res_t        div_res
);
  import pidvdt_pkg::*;

  logic signed [31:0] setpoint_r, gain_p_r, gain_i_r, gain_d_r;
  logic signed [31:0] limit_low_r, limit_high_r;
  logic [31:0]        last_time_r;
  logic signed [31:0] last_measure_r, integral_r;
  logic signed [31:0] meas_r;
  logic [31:0]        now_r, dt_r;
  logic signed [31:0] error_r, dm_r, p_r, qi_r, qd_r, dterm_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] drive_r;
  logic               out_valid_r;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_full;
  logic signed [31:0] q_val;
  logic signed [64:0] full_sum;
  logic               in_take, out_busy, res_wr, out_wr;

  assign in_stall = !ctrl.take_in;
  assign in_take  = in_valid && ctrl.take_in;
  assign out_busy = out_valid_r && out_stall;
  assign res_wr   = (ctrl.res_dst != RES_NONE) && !div_res.busy;
  assign out_wr   = (ctrl.out_op != OUT_NONE) && !out_busy;

  assign cond.in_take  = in_take;
  assign cond.skip     = (last_time_r == '0) || (dt_r == '0);
  assign cond.div_busy = div_res.busy;
  assign cond.out_busy = out_busy;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= '0;
      gain_p_r     <= '0;
      gain_i_r     <= '0;
      gain_d_r     <= '0;
      limit_low_r  <= S32_MIN;
      limit_high_r <= S32_MAX;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SETPOINT:   setpoint_r   <= cfg_wdata;
        REG_GAIN_P:     gain_p_r     <= cfg_wdata;
        REG_GAIN_I:     gain_i_r     <= cfg_wdata;
        REG_GAIN_D:     gain_d_r     <= cfg_wdata;
        REG_LIMIT_LOW:  limit_low_r  <= cfg_wdata;
        REG_LIMIT_HIGH: limit_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (ctrl.mul_sel)
      MUL_ERR_KP: begin
        mul_a = {error_r[31], error_r};
        mul_b = {gain_p_r[31], gain_p_r};
      end
      MUL_ERR_KI: begin
        mul_a = {error_r[31], error_r};
        mul_b = {gain_i_r[31], gain_i_r};
      end
      MUL_DM_KD: begin
        mul_a = {dm_r[31], dm_r};
        mul_b = {gain_d_r[31], gain_d_r};
      end
      MUL_QI_DT: begin
        mul_a = {qi_r[31], qi_r};
        mul_b = {1'b0, dt_r};
      end
      MUL_QD_MS: begin
        mul_a = {qd_r[31], qd_r};
        mul_b = {1'b0, MS_PER_S};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign q_val = qfix(prod_r);
  assign full_sum = sx65(p_r) + sx65(dterm_r) + sx65(integral_r);

  // divider request
  assign div_req.start    = (ctrl.div_op != DIV_NONE);
  assign div_req.by_dt    = (ctrl.div_op == DIV_BY_DT);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = (ctrl.div_op == DIV_BY_DT) ? dt_r : MS_PER_S;

  // working registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      meas_r <= in_measured_value;
      now_r  <= in_time_ms;
    end
    if (ctrl.prep) begin
      error_r <= sat32(sx65(setpoint_r) - sx65(meas_r));
      dm_r    <= sat32(sx65(last_measure_r) - sx65(meas_r));
      dt_r    <= now_r - last_time_r;
    end
    if (ctrl.mul_sel != MUL_NONE) begin
      prod_r <= prod_full[63:0];
    end
    unique case (ctrl.q_dst)
      Q_P:     p_r  <= q_val;
      Q_QI:    qi_r <= q_val;
      Q_QD:    qd_r <= q_val;
      default: ;
    endcase
    if (res_wr && (ctrl.res_dst == RES_DTERM)) begin
      dterm_r <= sat32($signed({div_res.quot[63], div_res.quot}));
    end
    if (out_wr) begin
      drive_r <= (ctrl.out_op == OUT_FULL)
                 ? clamp_lim(full_sum, limit_low_r, limit_high_r)
                 : clamp_lim(sx65(p_r), limit_low_r, limit_high_r);
    end
  end

  // controller state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r    <= '0;
      last_measure_r <= '0;
      integral_r     <= '0;
    end else begin
      if (res_wr && (ctrl.res_dst == RES_INTEGRAL)) begin
        integral_r <= clamp_lim(sx65(integral_r)
                                + $signed({div_res.quot[63], div_res.quot}),
                                limit_low_r, limit_high_r);
      end
      if (out_wr) begin
        last_time_r    <= now_r;
        last_measure_r <= meas_r;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive_value = drive_r;

endmodule

[rtl/pid_controller_variable_dt.sv]
// pid controller, derivative on measurement, variable time step (top level)
// full path: the shared divider divides by 1000 for the integral term and
//   by dt for the derivative term
// first sample or zero dt: P term only, the divider is skipped
// one sample at a time: input is taken only in idle, after the output is loaded
// reset: synchronous, restores register reset values and clears the stored state
module pid_controller_variable_dt (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [pidvdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_measured_value,
  input  logic [31:0]          in_time_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_drive_value
);
  import pidvdt_pkg::*;

`include "pid_controller_variable_dt_macros.svh"

  ctrl_t    ctrl;
  cond_t    cond;
  step_t    pc;
  div_req_t div_req;
  div_res_t div_res;

  // microcode sequencer
  pidvdt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cond  (cond),
    .ctrl  (ctrl),
    .pc    (pc)
  );

  // datapath
  pidvdt_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_measured_value (in_measured_value),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_value   (out_drive_value),
    .ctrl              (ctrl),
    .cond              (cond),
    .div_req           (div_req),
    .div_res           (div_res)
  );

  // shared divider
  pidvdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  // checks
  `PIDVDT_ASSERT_IMPL(a_take_only_idle, clk, rst_n, (in_valid && !in_stall), (pc == ST_IDLE))
  `PIDVDT_ASSERT_IMPL(a_div_busy_waits, clk, rst_n, div_res.busy, (ctrl.jmp == JMP_WAIT_DIV))
  `PIDVDT_ASSERT_IMPL(a_div_start_free, clk, rst_n, div_req.start, !div_res.busy)
  `PIDVDT_ASSERT_NEXT(a_out_load, clk, rst_n, ((ctrl.out_op != OUT_NONE) && !cond.out_busy), out_valid)

endmodule
